### rtl/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

   // Table sizes and the per-tick advance cap
   localparam int FRAME_ENTRIES = 256;
   localparam int ANIMATIONS    = 16;
   localparam int MAX_ADVANCES  = 256;

   localparam int FRAME_IDX_W = $clog2(FRAME_ENTRIES);
   localparam int ANIM_IDX_W  = $clog2(ANIMATIONS);
   localparam int STEP_W      = $clog2(MAX_ADVANCES + 1);

   // Field widths
   localparam int COMMAND_W  = 2;
   localparam int TIME_W     = 16;
   localparam int ANIM_W     = 4;
   localparam int ADDR_W     = 8;
   localparam int DURATION_W = 8;
   localparam int FRAME_W    = 8;
   localparam int FLAGS_W    = 8;

   // Request word layout, lowest bit first
   localparam int REQ_COMMAND_LSB  = 0;
   localparam int REQ_DELTA_LSB    = REQ_COMMAND_LSB + COMMAND_W;
   localparam int REQ_ANIM_LSB     = REQ_DELTA_LSB + TIME_W;
   localparam int REQ_ADDR_LSB     = REQ_ANIM_LSB + ANIM_W;
   localparam int REQ_DURATION_LSB = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_FIRST_LSB    = REQ_DURATION_LSB + DURATION_W;
   localparam int REQ_COUNT_LSB    = REQ_FIRST_LSB + FRAME_W;
   localparam int REQ_LOOP_LSB     = REQ_COUNT_LSB + FRAME_W;
   localparam int REQ_FLAGS_LSB    = REQ_LOOP_LSB + 1;
   localparam int REQ_USED_W       = REQ_FLAGS_LSB + FLAGS_W;
   localparam int REQ_DATA_W       = ((REQ_USED_W + 7) / 8) * 8;

   // Response word layout, lowest bit first
   localparam int RSP_PLAYING_LSB = 0;
   localparam int RSP_ANIM_LSB    = RSP_PLAYING_LSB + 1;
   localparam int RSP_FRAME_LSB   = RSP_ANIM_LSB + ANIM_W;
   localparam int RSP_FLAGS_LSB   = RSP_FRAME_LSB + FRAME_W;
   localparam int RSP_TIME_LSB    = RSP_FLAGS_LSB + FLAGS_W;
   localparam int RSP_USED_W      = RSP_TIME_LSB + TIME_W;
   localparam int RSP_DATA_W      = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_TICK           = 2'd0,
      CMD_START          = 2'd1,
      CMD_WRITE_DURATION = 2'd2,
      CMD_WRITE_ANIM     = 2'd3
   } command_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;      // carry out the accepted word's command
      logic fetch;     // read the current frame's duration
      logic advance;   // subtract the span and step one frame or stop
      logic load_out;  // capture state into the response register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic tick_go;   // incoming word is a tick while playing
      logic over;      // time exceeds the span and the cap is not reached
      logic last;      // next advance stops the animation
      logic playing;   // animation running
   } dp_sts_type;

endpackage

### rtl/animation_frame_sequencer_core.sv
`timescale 1ns / 1ps

// Animation frame sequencer. Commands load a 256-entry frame duration table
// and 16 animation descriptors, start an animation, or tick elapsed time; each
// request word returns one response word with the state after the command.
// A tick advances frames while the accumulated time exceeds ten times the
// current frame's duration, at most 256 advances per tick, wrapping or
// stopping after the last frame. One word is worked at a time. Table writes,
// starts and ticks while stopped go from idle straight to the respond state;
// a tick while playing alternates a fetch state (one duration memory read)
// and a check state (one compare-subtract per advance), skipping the closing
// fetch and check when its last advance stops the animation. The respond
// state waits while the previous response is still held, then loads the
// response word, held until it is taken. The next request is taken the cycle
// after the response is loaded, even if it is not yet consumed downstream.
module animation_frame_sequencer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // command, delta_time, animation, table_address, frame_duration,
   // first_frame, frame_count, loop_enable, draw_flags
   input  logic [afs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // playing, current_animation, current_frame, held_draw_flags, frame_time
   output logic [afs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   afs_pkg::dp_cmd_type dp_cmd;
   afs_pkg::dp_sts_type dp_sts;

   afs_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   afs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   // One word in flight: no acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a word is in flight");

   // Stopping advance clears playing
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.advance && dp_sts.last) |=> !dp_sts.playing)
      else $error("animation still playing after stop");

   // Loading the response raises valid
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |=> rsp_tvalid)
      else $error("response loaded without valid");

   // Advances only while working a word
   a_advance_busy: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.advance |-> !req_tready)
      else $error("frame advance while idle");

endmodule

### rtl/afs_control.sv
`timescale 1ns / 1ps

module afs_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output afs_pkg::dp_cmd_type dp_cmd,
   input  afs_pkg::dp_sts_type dp_sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequence one word: execute, walk frames on a tick, then respond
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      dp_cmd.exec     = 1'b0;
      dp_cmd.fetch    = 1'b0;
      dp_cmd.advance  = 1'b0;
      dp_cmd.load_out = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.exec = 1'b1;
               state_in    = dp_sts.tick_go ? ST_FETCH : ST_RESPOND;
            end
         end
         ST_FETCH: begin
            dp_cmd.fetch = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (dp_sts.over) begin
               dp_cmd.advance = 1'b1;
               state_in       = dp_sts.last ? ST_RESPOND : ST_FETCH;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               dp_cmd.load_out = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/afs_datapath.sv
`timescale 1ns / 1ps

module afs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [afs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [afs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  afs_pkg::dp_cmd_type                dp_cmd,
   output afs_pkg::dp_sts_type                dp_sts
);

   // Request fields
   afs_pkg::command_type                 req_command;
   logic [afs_pkg::TIME_W-1:0]           req_delta;
   logic [afs_pkg::ANIM_W-1:0]           req_anim;
   logic [afs_pkg::ADDR_W-1:0]           req_addr;
   logic [afs_pkg::DURATION_W-1:0]       req_duration;
   logic [afs_pkg::FRAME_W-1:0]          req_first;
   logic [afs_pkg::FRAME_W-1:0]          req_count;
   logic                                 req_loop;
   logic [afs_pkg::FLAGS_W-1:0]          req_flags;

   // Tables
   logic [afs_pkg::DURATION_W-1:0] duration_mem [afs_pkg::FRAME_ENTRIES];
   logic [afs_pkg::FRAME_W-1:0]    first_mem    [afs_pkg::ANIMATIONS];
   logic [afs_pkg::FRAME_W-1:0]    count_mem    [afs_pkg::ANIMATIONS];

   // Sequencer state
   logic [afs_pkg::ANIM_W-1:0]     active_ff;
   logic [afs_pkg::FRAME_W-1:0]    position_ff;
   logic [afs_pkg::TIME_W-1:0]     elapsed_ff;
   logic                           loop_ff;
   logic                           playing_ff;
   logic [afs_pkg::FLAGS_W-1:0]    flags_ff;
   logic [afs_pkg::STEP_W-1:0]     steps_ff;
   logic [afs_pkg::DURATION_W-1:0] duration_ff;
   logic [afs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [afs_pkg::ANIM_IDX_W-1:0]  anim_idx;
   logic [afs_pkg::FRAME_W-1:0]     anim_first;
   logic [afs_pkg::FRAME_W-1:0]     anim_count;
   logic [afs_pkg::FRAME_W:0]       index_sum;
   logic [afs_pkg::FRAME_IDX_W-1:0] fetch_addr;
   logic [afs_pkg::TIME_W-1:0]      span;
   logic [afs_pkg::FRAME_W:0]       next_position;
   logic                            has_next;

   assign req_command  = afs_pkg::command_type'(
                            req_tdata[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W]);
   assign req_delta    = req_tdata[afs_pkg::REQ_DELTA_LSB +: afs_pkg::TIME_W];
   assign req_anim     = req_tdata[afs_pkg::REQ_ANIM_LSB +: afs_pkg::ANIM_W];
   assign req_addr     = req_tdata[afs_pkg::REQ_ADDR_LSB +: afs_pkg::ADDR_W];
   assign req_duration = req_tdata[afs_pkg::REQ_DURATION_LSB +: afs_pkg::DURATION_W];
   assign req_first    = req_tdata[afs_pkg::REQ_FIRST_LSB +: afs_pkg::FRAME_W];
   assign req_count    = req_tdata[afs_pkg::REQ_COUNT_LSB +: afs_pkg::FRAME_W];
   assign req_loop     = req_tdata[afs_pkg::REQ_LOOP_LSB];
   assign req_flags    = req_tdata[afs_pkg::REQ_FLAGS_LSB +: afs_pkg::FLAGS_W];

   // Descriptor of the active animation; table count is a power of two
   assign anim_idx   = active_ff[afs_pkg::ANIM_IDX_W-1:0];
   assign anim_first = first_mem[anim_idx];
   assign anim_count = count_mem[anim_idx];

   // Duration entry wraps around the frame table
   assign index_sum  = {1'b0, anim_first} + {1'b0, position_ff};
   assign fetch_addr = index_sum[afs_pkg::FRAME_IDX_W-1:0];

   // Span is ten times the stored duration: 8x + 2x
   assign span = (afs_pkg::TIME_W'(duration_ff) << 3) + (afs_pkg::TIME_W'(duration_ff) << 1);

   assign next_position = {1'b0, position_ff} + 1'b1;
   assign has_next      = (anim_count != '0) && (next_position < {1'b0, anim_count});

   assign dp_sts.tick_go = (req_command == afs_pkg::CMD_TICK) && playing_ff;
   assign dp_sts.over    = (elapsed_ff > span) &&
                           (steps_ff < afs_pkg::STEP_W'(afs_pkg::MAX_ADVANCES));
   assign dp_sts.last    = !has_next && !loop_ff;
   assign dp_sts.playing = playing_ff;

   assign rsp_tdata = rsp_data_ff;

   // Write tables and read the duration memory
   always_ff @(posedge clock) begin
      if (dp_cmd.exec && (req_command == afs_pkg::CMD_WRITE_DURATION) &&
          (int'(req_addr) < afs_pkg::FRAME_ENTRIES)) begin
         duration_mem[req_addr[afs_pkg::FRAME_IDX_W-1:0]] <= req_duration;
      end
      if (dp_cmd.exec && (req_command == afs_pkg::CMD_WRITE_ANIM) &&
          (int'(req_anim) < afs_pkg::ANIMATIONS)) begin
         first_mem[req_anim[afs_pkg::ANIM_IDX_W-1:0]] <= req_first;
         count_mem[req_anim[afs_pkg::ANIM_IDX_W-1:0]] <= req_count;
      end
      if (dp_cmd.fetch) begin
         duration_ff <= duration_mem[fetch_addr];
      end
   end

   // Apply commands and frame advances
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         position_ff <= '0;
         elapsed_ff  <= '0;
         loop_ff     <= 1'b0;
         playing_ff  <= 1'b0;
         flags_ff    <= '0;
         steps_ff    <= '0;
      end else if (dp_cmd.exec) begin
         case (req_command)
            afs_pkg::CMD_TICK: begin
               if (playing_ff) begin
                  elapsed_ff <= elapsed_ff + req_delta;
                  steps_ff   <= '0;
               end
            end
            afs_pkg::CMD_START: begin
               active_ff   <= req_anim;
               position_ff <= '0;
               flags_ff    <= req_flags;
               elapsed_ff  <= '0;
               loop_ff     <= req_loop;
               playing_ff  <= 1'b1;
            end
            default: begin
            end
         endcase
      end else if (dp_cmd.advance) begin
         elapsed_ff <= elapsed_ff - span;
         steps_ff   <= steps_ff + 1'b1;
         if (has_next) begin
            position_ff <= next_position[afs_pkg::FRAME_W-1:0];
         end else if (loop_ff) begin
            position_ff <= '0;
         end else begin
            playing_ff <= 1'b0;
         end
      end
   end

   // Capture the response word
   always_ff @(posedge clock) begin
      if (dp_cmd.load_out) begin
         rsp_data_ff <= afs_pkg::RSP_DATA_W'({elapsed_ff, flags_ff, position_ff,
                                              active_ff, playing_ff});
      end
   end

endmodule

### test/animation_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps

module animation_frame_sequencer_core_tb;

   localparam int DURATION_SCALE = 10;
   localparam int RANDOM_WORDS   = 1400;
   localparam int IDLE_LIMIT     = 20000;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 2500;
   localparam int TAIL_CYCLES    = 600;

   typedef struct packed {
      logic                          playing;
      logic [afs_pkg::ANIM_W-1:0]    animation;
      logic [afs_pkg::FRAME_W-1:0]   frame;
      logic [afs_pkg::FLAGS_W-1:0]   flags;
      logic [afs_pkg::TIME_W-1:0]    frame_time;
   } seq_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [afs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [afs_pkg::RSP_DATA_W-1:0] rsp_tdata;

   animation_frame_sequencer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Words waiting to be sent and responses waiting to arrive
   logic [afs_pkg::REQ_DATA_W-1:0] pending_words [$];
   seq_rsp_type                    expected_rsp [$];

   // Shadow copy of the sequencer state
   logic [afs_pkg::DURATION_W-1:0] dur_mem   [afs_pkg::FRAME_ENTRIES];
   logic [afs_pkg::FRAME_W-1:0]    first_mem [afs_pkg::ANIMATIONS];
   logic [afs_pkg::FRAME_W-1:0]    count_mem [afs_pkg::ANIMATIONS];
   logic [afs_pkg::ANIM_W-1:0]     sq_anim    = '0;
   logic [afs_pkg::FRAME_W-1:0]    sq_frame   = '0;
   logic [afs_pkg::TIME_W-1:0]     sq_time    = '0;
   logic                           sq_loop    = 1'b0;
   logic                           sq_playing = 1'b0;
   logic [afs_pkg::FLAGS_W-1:0]    sq_flags   = '0;

   int errors       = 0;
   int words_seen   = 0;
   int ticks_seen   = 0;
   int capped_ticks = 0;
   int stops_seen   = 0;
   int starts_seen  = 0;
   int writes_seen  = 0;

   // Span, ten times the duration, of the current frame of an animation that begins at base
   function automatic logic [afs_pkg::TIME_W-1:0] span_at(logic [afs_pkg::FRAME_W-1:0] base);
      return afs_pkg::TIME_W'(
         int'(dur_mem[(int'(base) + int'(sq_frame)) % afs_pkg::FRAME_ENTRIES])
         * DURATION_SCALE);
   endfunction

   // Apply one request word to the shadow state and return the response
   function automatic seq_rsp_type predict_sequencer(logic [afs_pkg::REQ_DATA_W-1:0] w);
      afs_pkg::command_type          cmd;
      logic [afs_pkg::TIME_W-1:0]    dt;
      logic [afs_pkg::ANIM_W-1:0]    anim;
      logic [afs_pkg::ADDR_W-1:0]    addr;
      logic [afs_pkg::FRAME_W-1:0]   base;
      logic [afs_pkg::FRAME_W-1:0]   cnt;
      logic [afs_pkg::TIME_W-1:0]    span;
      int                            steps;
      bit                            stopped;
      seq_rsp_type                   r;
      cmd  = afs_pkg::command_type'(w[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W]);
      dt   = w[afs_pkg::REQ_DELTA_LSB +: afs_pkg::TIME_W];
      anim = w[afs_pkg::REQ_ANIM_LSB +: afs_pkg::ANIM_W];
      addr = w[afs_pkg::REQ_ADDR_LSB +: afs_pkg::ADDR_W];
      words_seen++;
      case (cmd)
         afs_pkg::CMD_TICK: begin
            ticks_seen++;
            if (sq_playing) begin
               base    = first_mem[int'(sq_anim) % afs_pkg::ANIMATIONS];
               cnt     = count_mem[int'(sq_anim) % afs_pkg::ANIMATIONS];
               span    = span_at(base);
               sq_time = sq_time + dt;
               steps   = 0;
               stopped = 1'b0;
               while (!stopped && sq_time > span && steps < afs_pkg::MAX_ADVANCES) begin
                  steps++;
                  sq_time = sq_time - span;
                  if (cnt != 0 && int'(sq_frame) + 1 < int'(cnt)) begin
                     sq_frame = sq_frame + 1'b1;
                  end else if (sq_loop) begin
                     sq_frame = '0;
                  end else begin
                     sq_playing = 1'b0;
                     stopped    = 1'b1;
                     stops_seen++;
                  end
                  if (!stopped) span = span_at(base);
               end
               if (steps == afs_pkg::MAX_ADVANCES) capped_ticks++;
            end
         end
         afs_pkg::CMD_START: begin
            starts_seen++;
            sq_anim    = anim;
            sq_frame   = '0;
            sq_flags   = w[afs_pkg::REQ_FLAGS_LSB +: afs_pkg::FLAGS_W];
            sq_time    = '0;
            sq_loop    = w[afs_pkg::REQ_LOOP_LSB];
            sq_playing = 1'b1;
         end
         afs_pkg::CMD_WRITE_DURATION: begin
            writes_seen++;
            if (int'(addr) < afs_pkg::FRAME_ENTRIES) begin
               dur_mem[addr] = w[afs_pkg::REQ_DURATION_LSB +: afs_pkg::DURATION_W];
            end
         end
         default: begin
            writes_seen++;
            if (int'(anim) < afs_pkg::ANIMATIONS) begin
               first_mem[anim] = w[afs_pkg::REQ_FIRST_LSB +: afs_pkg::FRAME_W];
               count_mem[anim] = w[afs_pkg::REQ_COUNT_LSB +: afs_pkg::FRAME_W];
            end
         end
      endcase
      r.playing    = sq_playing;
      r.animation  = sq_anim;
      r.frame      = sq_frame;
      r.flags      = sq_flags;
      r.frame_time = sq_time;
      return r;
   endfunction

   // Stimulus building: every field starts random, the command's own fields are set after
   function automatic logic [afs_pkg::REQ_DATA_W-1:0] rand_word();
      logic [afs_pkg::REQ_DATA_W-1:0] w;
      w = {$urandom, $urandom};
      w[afs_pkg::REQ_DATA_W-1:afs_pkg::REQ_USED_W] = '0;
      return w;
   endfunction

   function automatic void put_tick(logic [afs_pkg::TIME_W-1:0] dt);
      logic [afs_pkg::REQ_DATA_W-1:0] w;
      w = rand_word();
      w[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W] = afs_pkg::CMD_TICK;
      w[afs_pkg::REQ_DELTA_LSB +: afs_pkg::TIME_W]      = dt;
      pending_words.push_back(w);
   endfunction

   function automatic void put_start(logic [afs_pkg::ANIM_W-1:0] anim, logic loop_en,
                                     logic [afs_pkg::FLAGS_W-1:0] flags);
      logic [afs_pkg::REQ_DATA_W-1:0] w;
      w = rand_word();
      w[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W] = afs_pkg::CMD_START;
      w[afs_pkg::REQ_ANIM_LSB +: afs_pkg::ANIM_W]       = anim;
      w[afs_pkg::REQ_LOOP_LSB]                          = loop_en;
      w[afs_pkg::REQ_FLAGS_LSB +: afs_pkg::FLAGS_W]     = flags;
      pending_words.push_back(w);
   endfunction

   function automatic void put_duration(logic [afs_pkg::ADDR_W-1:0] addr,
                                        logic [afs_pkg::DURATION_W-1:0] dur);
      logic [afs_pkg::REQ_DATA_W-1:0] w;
      w = rand_word();
      w[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W]   = afs_pkg::CMD_WRITE_DURATION;
      w[afs_pkg::REQ_ADDR_LSB +: afs_pkg::ADDR_W]         = addr;
      w[afs_pkg::REQ_DURATION_LSB +: afs_pkg::DURATION_W] = dur;
      pending_words.push_back(w);
   endfunction

   function automatic void put_anim(logic [afs_pkg::ANIM_W-1:0] anim,
                                    logic [afs_pkg::FRAME_W-1:0] first_f,
                                    logic [afs_pkg::FRAME_W-1:0] count_f);
      logic [afs_pkg::REQ_DATA_W-1:0] w;
      w = rand_word();
      w[afs_pkg::REQ_COMMAND_LSB +: afs_pkg::COMMAND_W] = afs_pkg::CMD_WRITE_ANIM;
      w[afs_pkg::REQ_ANIM_LSB +: afs_pkg::ANIM_W]       = anim;
      w[afs_pkg::REQ_FIRST_LSB +: afs_pkg::FRAME_W]     = first_f;
      w[afs_pkg::REQ_COUNT_LSB +: afs_pkg::FRAME_W]     = count_f;
      pending_words.push_back(w);
   endfunction

   // Short durations are favoured so that ticks walk through many frames
   function automatic logic [afs_pkg::DURATION_W-1:0] rand_duration();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 45) return afs_pkg::DURATION_W'($urandom_range(1, 8));
      return afs_pkg::DURATION_W'($urandom_range(0, 255));
   endfunction

   // Mostly short animations, so wraps and stops come often
   function automatic logic [afs_pkg::FRAME_W-1:0] rand_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) return '0;
      if (pick < 11) return afs_pkg::FRAME_W'(255);
      if (pick < 80) return afs_pkg::FRAME_W'($urandom_range(1, 6));
      return afs_pkg::FRAME_W'($urandom_range(7, 40));
   endfunction

   task automatic check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         errors++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_words.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: changing stall patterns plus one long hold-off
   int       rsp_taken = 0;
   int       hold_left = 0;
   bit       hold_done = 1'b0;
   int       rx_mode   = 0;
   int       mode_left = 0;
   bit [7:0] rx_phase  = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_taken <= rsp_taken + 1;
         rx_phase <= rx_phase + 1'b1;
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_taken >= HOLD_AFTER) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   <= $urandom_range(0, 3);
               mode_left <= $urandom_range(32, 256);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (rx_phase[1:0] != 2'd0);
               default: rsp_tready <= (rx_phase[2:0] == 3'd0);
            endcase
         end
      end
   end

   // Predict on each accepted request word, check each accepted response word
   int idle_cycles = 0;

   always @(posedge clock) begin : monitor
      seq_rsp_type got;
      seq_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_rsp.push_back(predict_sequencer(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.playing    = rsp_tdata[afs_pkg::RSP_PLAYING_LSB];
            got.animation  = rsp_tdata[afs_pkg::RSP_ANIM_LSB +: afs_pkg::ANIM_W];
            got.frame      = rsp_tdata[afs_pkg::RSP_FRAME_LSB +: afs_pkg::FRAME_W];
            got.flags      = rsp_tdata[afs_pkg::RSP_FLAGS_LSB +: afs_pkg::FLAGS_W];
            got.frame_time = rsp_tdata[afs_pkg::RSP_TIME_LSB +: afs_pkg::TIME_W];
            if (expected_rsp.size() == 0) begin
               $error("response word with no request outstanding");
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("playing", want.playing, got.playing);
               check_field("current_animation", want.animation, got.animation);
               check_field("current_frame", want.frame, got.frame);
               check_field("held_draw_flags", want.flags, got.flags);
               check_field("frame_time", want.frame_time, got.frame_time);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
         $display("animation_frame_sequencer_core_tb failed");
         $finish;
      end
   end

   initial begin
      int pick;
      int n;

      // Tick before anything is playing
      put_tick(16'd1234);

      // Load every table entry so that no tick reads an unwritten one
      for (n = 0; n < afs_pkg::FRAME_ENTRIES; n++) begin
         put_duration(afs_pkg::ADDR_W'(n), rand_duration());
      end
      for (n = 0; n < afs_pkg::ANIMATIONS; n++) begin
         put_anim(afs_pkg::ANIM_W'(n), afs_pkg::FRAME_W'($urandom), rand_count());
      end

      // Duration index wraps past the end of the table; big ticks and time wrap
      put_duration(8'd0, 8'd0);
      put_duration(8'd255, 8'd255);
      put_anim(4'd0, 8'd255, 8'd2);
      put_start(4'd0, 1'b1, 8'hFF);
      put_tick(16'hFFFF);
      put_tick(16'hFFFF);

      // Zero frame count: stop, tick while stopped, then looping at the advance cap
      put_duration(8'd40, 8'd0);
      put_anim(4'd15, 8'd40, 8'd0);
      put_start(4'd15, 1'b0, 8'h00);
      put_tick(16'd1);
      put_tick(16'd100);
      put_start(4'd15, 1'b1, 8'h5A);
      put_tick(16'd1000);
      put_tick(16'd0);

      // Three-frame animation: exact span holds, then advance and stop on the last frame
      put_duration(8'd10, 8'd1);
      put_duration(8'd11, 8'd2);
      put_duration(8'd12, 8'd3);
      put_anim(4'd7, 8'd10, 8'd3);
      put_start(4'd7, 1'b0, 8'hA5);
      put_tick(16'd10);
      put_tick(16'd1);
      put_tick(16'd60);
      put_tick(16'd0);

      // Random traffic: ticks dominate, with restarts and table rewrites mixed in
      for (n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            put_anim(afs_pkg::ANIM_W'($urandom), afs_pkg::FRAME_W'($urandom), rand_count());
         end else if (pick < 22) begin
            put_duration(afs_pkg::ADDR_W'($urandom), rand_duration());
         end else if (pick < 36) begin
            put_start(afs_pkg::ANIM_W'($urandom), 1'($urandom), afs_pkg::FLAGS_W'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) put_tick('0);
            else if (pick < 12) put_tick(16'hFFFF);
            else if (pick < 20) put_tick(afs_pkg::TIME_W'($urandom));
            else put_tick(afs_pkg::TIME_W'($urandom_range(0, 3000)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every response in, then let the block settle
      while (pending_words.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d words: %0d ticks, %0d starts, %0d table writes",
               words_seen, ticks_seen, starts_seen, writes_seen);
      $display("ticks at the advance cap: %0d, stops at the last frame: %0d",
               capped_ticks, stops_seen);
      if (errors == 0) begin
         $display("animation_frame_sequencer_core_tb passed");
      end else begin
         $display("animation_frame_sequencer_core_tb failed");
      end
      $finish;
   end

endmodule
